FILE: rtl/two_class_fifo_aged_drain_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-class aged drain unit
// Clocked on clk_i, switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_FIFO_AGED_DRAIN_UNIT_MACROS_SVH
`define TWO_CLASS_FIFO_AGED_DRAIN_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TCFAD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TCFAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tcfad_pkg.sv
// ----------------------------------------------------------------------------
// tcfad_pkg
// Types and codes shared by the two-class aged drain unit.
// ----------------------------------------------------------------------------
package tcfad_pkg;

  // width of the arrival stamp, compared modulo its range
  localparam int unsigned StampW = 7;

  // command codes
  localparam logic [2:0] KIND_ADD       = 3'd0;
  localparam logic [2:0] KIND_DRAIN_B   = 3'd1;
  localparam logic [2:0] KIND_DRAIN_A   = 3'd2;
  localparam logic [2:0] KIND_DRAIN_ALL = 3'd3;
  localparam logic [2:0] KIND_EMPTY_B   = 3'd4;
  localparam logic [2:0] KIND_EMPTY_A   = 3'd5;
  localparam logic [2:0] KIND_EMPTY_ALL = 3'd6;
  localparam logic [2:0] KIND_RESERVED  = 3'd7;

  // result codes
  localparam logic [1:0] RES_DRAINED = 2'd0;
  localparam logic [1:0] RES_ANSWER  = 2'd1;
  localparam logic [1:0] RES_DROPPED = 2'd2;

  // class codes
  localparam logic CLASS_A = 1'b0;
  localparam logic CLASS_B = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic        item_class;
    logic [31:0] item_id;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        out_class;
    logic [31:0] out_id;
    logic        answer_yes;
    logic        last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic       push;
    logic       pop_a;
    logic       pop_b;
    logic       emit;
    logic [1:0] res_kind;
    logic       answer_yes;
    logic       last;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic a_empty;
    logic b_empty;
    logic a_full;
    logic b_full;
    logic a_single;
    logic b_single;
    logic a_older;
  } ctl_stat_t;

endpackage

FILE: rtl/tcfad_queue.sv
// ----------------------------------------------------------------------------
// tcfad_queue
// Circular FIFO of identifiers and arrival stamps for one class.
// ----------------------------------------------------------------------------
module tcfad_queue import tcfad_pkg::*; #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IdW   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              pop_i,
  input  logic [IdW-1:0]    id_i,
  input  logic [StampW-1:0] stamp_i,
  output logic [IdW-1:0]    head_id_o,
  output logic [StampW-1:0] head_stamp_o,
  output logic              empty_o,
  output logic              full_o,
  output logic              single_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
  localparam logic [SumW-1:0] DepthSum = SumW'(DEPTH);

  logic [IdW-1:0]    id_mem    [DEPTH];
  logic [StampW-1:0] stamp_mem [DEPTH];

  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [SumW-1:0] tail_sum;
  logic [PtrW-1:0] tail;

  // locate the free slot behind the last entry
  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign tail     = (tail_sum >= DepthSum) ? PtrW'(tail_sum - DepthSum) : PtrW'(tail_sum);

  // store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      id_mem[tail]    <= id_i;
      stamp_mem[tail] <= stamp_i;
    end
  end

  // advance head and count
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (pop_i) begin
      head_d = (head_q == LastPtr) ? '0 : head_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  assign head_id_o    = id_mem[head_q];
  assign head_stamp_o = stamp_mem[head_q];
  assign empty_o      = (count_q == '0);
  assign full_o       = (count_q == DepthCnt);
  assign single_o     = (count_q == CntW'(1));

endmodule

FILE: rtl/tcfad_datapath.sv
// ----------------------------------------------------------------------------
// tcfad_datapath
// Both class queues, the arrival stamp counter and the result register.
// ----------------------------------------------------------------------------
module tcfad_datapath import tcfad_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned ID_WIDTH    = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_t       cmd_i,
  input  ctl_cmd_t  ctl_i,
  output ctl_stat_t stat_o,
  output logic      res_valid_o,
  output out_t      res_o
);

  // only the low 32 bits of an id ever leave the block
  localparam int unsigned IdW = (ID_WIDTH < 32) ? ID_WIDTH : 32;

  logic [StampW-1:0] stamp_q, stamp_d;
  logic [IdW-1:0]    a_id, b_id, in_id;
  logic [StampW-1:0] a_stamp, b_stamp, stamp_diff;
  logic              push_a, push_b;
  logic              res_valid_q;
  out_t              res_q, res_d;

  assign in_id  = cmd_i.item_id[IdW-1:0];
  assign push_a = ctl_i.push && (cmd_i.item_class == CLASS_A);
  assign push_b = ctl_i.push && (cmd_i.item_class == CLASS_B);

  tcfad_queue #(
    .DEPTH (QUEUE_DEPTH),
    .IdW   (IdW)
  ) u_queue_a (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_a),
    .pop_i        (ctl_i.pop_a),
    .id_i         (in_id),
    .stamp_i      (stamp_q),
    .head_id_o    (a_id),
    .head_stamp_o (a_stamp),
    .empty_o      (stat_o.a_empty),
    .full_o       (stat_o.a_full),
    .single_o     (stat_o.a_single)
  );

  tcfad_queue #(
    .DEPTH (QUEUE_DEPTH),
    .IdW   (IdW)
  ) u_queue_b (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_b),
    .pop_i        (ctl_i.pop_b),
    .id_i         (in_id),
    .stamp_i      (stamp_q),
    .head_id_o    (b_id),
    .head_stamp_o (b_stamp),
    .empty_o      (stat_o.b_empty),
    .full_o       (stat_o.b_full),
    .single_o     (stat_o.b_single)
  );

  // class A head is older when the wrapped difference is negative
  assign stamp_diff     = a_stamp - b_stamp;
  assign stat_o.a_older = stamp_diff[StampW-1];

  // advance the stamp on every stored add
  assign stamp_d = ctl_i.push ? stamp_q + 1'b1 : stamp_q;

  // build the result item
  always_comb begin
    res_d             = '0;
    res_d.result_kind = ctl_i.res_kind;
    res_d.answer_yes  = ctl_i.answer_yes;
    res_d.last        = ctl_i.last;
    case (ctl_i.res_kind)
      RES_DRAINED: begin
        res_d.out_class = ctl_i.pop_b ? CLASS_B : CLASS_A;
        res_d.out_id    = ctl_i.pop_b ? 32'(b_id) : 32'(a_id);
      end
      RES_DROPPED: begin
        res_d.out_class = cmd_i.item_class;
        res_d.out_id    = 32'(in_id);
      end
      default: begin
        res_d.out_class = CLASS_A;
        res_d.out_id    = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      stamp_q     <= stamp_d;
      res_valid_q <= ctl_i.emit;
    end
  end

  // hold the payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/tcfad_ctrl.sv
// ----------------------------------------------------------------------------
// tcfad_ctrl
// Command decoder and drain sequencer.
// ----------------------------------------------------------------------------
module tcfad_ctrl import tcfad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  in_t       cmd_i,
  input  ctl_stat_t stat_i,
  output ctl_cmd_t  ctl_o,
  output logic      busy
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic       state_q, state_d;
  logic [2:0] mode_q, mode_d;
  logic       take_a, take_b, fin;

  // pick the queue to pop and spot the final entry of the drain
  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    fin    = 1'b0;
    unique case (mode_q) inside
      KIND_DRAIN_A: begin
        take_a = !stat_i.a_empty;
        fin    = stat_i.a_single;
      end
      KIND_DRAIN_B: begin
        take_b = !stat_i.b_empty;
        fin    = stat_i.b_single;
      end
      default: begin
        if (!stat_i.a_empty && !stat_i.b_empty) begin
          take_a = stat_i.a_older;
          take_b = !stat_i.a_older;
        end else begin
          take_a = !stat_i.a_empty;
          take_b = !stat_i.b_empty;
        end
        fin = (stat_i.a_single && stat_i.b_empty) || (stat_i.b_single && stat_i.a_empty);
      end
    endcase
  end

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    mode_d  = mode_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd_i.kind) inside
            KIND_ADD: begin
              if ((cmd_i.item_class == CLASS_B) ? stat_i.b_full : stat_i.a_full) begin
                ctl_o.emit     = 1'b1;
                ctl_o.res_kind = RES_DROPPED;
                ctl_o.last     = 1'b1;
              end else begin
                ctl_o.push = 1'b1;
              end
            end
            KIND_DRAIN_B, KIND_DRAIN_A, KIND_DRAIN_ALL: begin
              mode_d  = cmd_i.kind;
              state_d = ST_DRAIN;
            end
            KIND_EMPTY_B: begin
              ctl_o.emit       = 1'b1;
              ctl_o.res_kind   = RES_ANSWER;
              ctl_o.answer_yes = stat_i.b_empty;
              ctl_o.last       = 1'b1;
            end
            KIND_EMPTY_A: begin
              ctl_o.emit       = 1'b1;
              ctl_o.res_kind   = RES_ANSWER;
              ctl_o.answer_yes = stat_i.a_empty;
              ctl_o.last       = 1'b1;
            end
            KIND_EMPTY_ALL, KIND_RESERVED: begin
              ctl_o.emit       = 1'b1;
              ctl_o.res_kind   = RES_ANSWER;
              ctl_o.answer_yes = stat_i.a_empty && stat_i.b_empty;
              ctl_o.last       = 1'b1;
            end
            default: begin
              ctl_o = '0;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        // pop one entry a cycle, drop back to idle once nothing is left
        if (take_a || take_b) begin
          ctl_o.pop_a    = take_a;
          ctl_o.pop_b    = take_b;
          ctl_o.emit     = 1'b1;
          ctl_o.res_kind = RES_DRAINED;
          ctl_o.last     = fin;
          if (fin) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= KIND_DRAIN_ALL;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  assign busy = (state_q == ST_DRAIN);

endmodule

FILE: rtl/two_class_fifo_aged_drain_unit.sv
// Adds and queries: taken while not busy; a query or dropped add gives its
// result in the cycle after the command, a stored add none. Drains start the
// pop sequencer (busy while it runs): one result per cycle to the last entry,
// none if empty; the merged drain picks the older head by stamp each cycle.
// Reset clears heads, counts, stamp counter and sequencer; storage keeps
// stale contents. The receiver cannot stall: each result shows for one cycle.
// ----------------------------------------------------------------------------
// two_class_fifo_aged_drain_unit
// Two per-class FIFOs with arrival stamps, class and merged drains, queries.
// ----------------------------------------------------------------------------
`include "two_class_fifo_aged_drain_unit_macros.svh"

module two_class_fifo_aged_drain_unit import tcfad_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned ID_WIDTH    = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  in_t  cmd_i,
  output logic busy,
  output logic res_valid_o,
  output out_t res_o
);

  ctl_cmd_t  ctl;
  ctl_stat_t stat;
  logic      add_full;

  tcfad_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .stat_i (stat),
    .ctl_o  (ctl),
    .busy   (busy)
  );

  tcfad_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // queue addressed by the offered add is full
  assign add_full = cmd_i.item_class ? stat.b_full : stat.a_full;

  // never pop an empty queue
  `TCFAD_ASSERT_SAME(a_pop_nonempty, ctl.pop_a, !stat.a_empty, "pop of empty class A queue")
  `TCFAD_ASSERT_SAME(b_pop_nonempty, ctl.pop_b, !stat.b_empty, "pop of empty class B queue")
  // a stored add never lands in a full queue
  `TCFAD_ASSERT_SAME(push_not_full, ctl.push, !add_full, "push into full queue")
  // every emit shows on the result port in the next cycle
  `TCFAD_ASSERT_NEXT(emit_shows, ctl.emit, res_valid_o, "emitted item missing on result port")
  // a stored add gives no result
  `TCFAD_ASSERT_NEXT(add_silent, start && !busy && ctl.push, !res_valid_o, "result after stored add")

endmodule
